@@ src/tops_pkg.sv @@
// Package for the timestamp ordered packet scheduler: sizes, codes, queue entry type.
// No dependencies.
package tops_pkg;
  localparam int SlotCount = 16;
  localparam int MaxBytes = 64;
  localparam int SlotW = 4;
  localparam int ByteW = 6;
  localparam int LenW = 7;
  localparam int AddrW = SlotW + ByteW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_GET = 2'd1, OP_FREE = 2'd2, OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BAD_SLOT = 3'd3, ST_TOO_LONG = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0, BK_SEND = 2'd1, BK_SCAN = 2'd2
  } bk_state_t;

  // front-to-back command: one add byte, a get or a free
  typedef struct packed {
    op_t         op;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [7:0]  data;
    logic        fin;
    logic [7:0]  idx;
  } cmd_t;
endpackage

@@ src/tops_if.sv @@
// Valid/ready channel interfaces for the scheduler.
// No dependencies.
interface tops_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] stamp_seconds;
  logic [19:0] stamp_micros;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic [7:0]  slot_index;
  modport source (output valid, opcode, stamp_seconds, stamp_micros, data_byte,
                  final_byte, slot_index, input ready);
  modport sink (input valid, opcode, stamp_seconds, stamp_micros, data_byte,
                final_byte, slot_index, output ready);
endinterface

interface tops_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot_number;
  logic [31:0] out_seconds;
  logic [19:0] out_micros;
  logic [6:0]  packet_length;
  logic [7:0]  out_byte;
  logic        last_result;
  modport source (output valid, status, slot_number, out_seconds, out_micros,
                  packet_length, out_byte, last_result, input ready);
  modport sink (input valid, status, slot_number, out_seconds, out_micros,
                packet_length, out_byte, last_result, output ready);
endinterface

@@ src/timestamp_ordered_packet_scheduler_unit.sv @@
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | opcode, stamp, data_byte, final_byte, slot_index
// out     | out | out_valid/out_ready| status, slot, stamp, length, out_byte, last_result
// Each add byte is taken as its own request. A get takes the request, then for each
// payload byte a memory read then the output register, then releases the slot and
// rescans all 16 slot table entries; a valid free takes its request and then rescans
// the table. Reset is synchronous, active low, and clears the table at once. A
// stalled output holds the back end; the 2-entry queue keeps taking requests until
// it fills.
module timestamp_ordered_packet_scheduler_unit
  import tops_pkg::*;
(
  input logic clk,
  input logic rst_n,
  tops_in_if.sink in_ch,
  tops_out_if.source out_ch
);
  logic q_full, q_push, q_pop, q_ne;
  cmd_t q_cmd, q_head;

  tops_front u_front (.in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd));
  tops_queue u_queue (.clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd),
                      .full(q_full), .pop(q_pop), .nonempty(q_ne), .head(q_head));
  tops_back u_back (.clk(clk), .rst_n(rst_n), .q_nonempty(q_ne), .q_head(q_head),
                    .q_pop(q_pop), .out_ch(out_ch));
endmodule

@@ src/tops_queue.sv @@
// Two-entry command queue between front and back.
// Depends on tops_pkg.
module tops_queue
  import tops_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ src/tops_back.sv @@
// Back end: slot table, payload memory, due tracking, rescans, result streaming.
// Depends on tops_pkg.
module tops_back
  import tops_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_nonempty,
  input  cmd_t q_head,
  output logic q_pop,
  tops_out_if.source out_ch
);
  logic [SlotCount-1:0] valid_r, valid_nxt;
  logic [31:0] sec_r [SlotCount];
  logic [19:0] usec_r [SlotCount];
  logic [LenW-1:0] len_r [SlotCount];
  logic [7:0] pay_mem [SlotCount*MaxBytes];

  logic [SlotW-1:0] due_r, due_nxt;
  logic due_p_r, due_p_nxt;
  logic fill_act_r, fill_act_nxt;
  logic [SlotW-1:0] fslot_r, fslot_nxt;
  logic [LenW-1:0] fcnt_r, fcnt_nxt;
  status_t ferr_r, ferr_nxt;

  bk_state_t st_r, st_nxt;
  logic [SlotW-1:0] ss_r, ss_nxt;        // slot being sent
  logic [LenW-1:0] k_r, k_nxt;           // byte index being read
  logic [LenW-1:0] slen_r, slen_nxt;
  logic [SlotW:0] sc_r, sc_nxt;          // rescan index
  logic rd_pend_r, rd_pend_nxt;          // memory read data waiting in rd_q_r
  logic [7:0] rd_q_r;

  logic ov_r, ov_nxt;
  logic [2:0] o_st_r, o_st_nxt;
  logic [3:0] o_slot_r, o_slot_nxt;
  logic [31:0] o_sec_r, o_sec_nxt;
  logic [19:0] o_usec_r, o_usec_nxt;
  logic [6:0] o_len_r, o_len_nxt;
  logic [7:0] o_byte_r, o_byte_nxt;
  logic o_last_r, o_last_nxt;

  logic wr_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic rd_en;
  logic set_en, clr_en;
  logic [SlotW-1:0] set_slot, clr_slot;
  logic out_free;
  logic [SlotW-1:0] low_free;
  logic any_free;
  logic [51:0] cand_key, due_key, new_key;
  logic [SlotW-1:0] sc_idx;

  assign out_free = !ov_r || out_ch.ready;
  assign sc_idx = sc_r[SlotW-1:0];
  assign cand_key = {sec_r[sc_idx], usec_r[sc_idx]};
  assign due_key = {sec_r[due_r], usec_r[due_r]};
  assign new_key = {q_head.sec, q_head.usec};

  always_comb begin
    low_free = '0;
    any_free = 1'b0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        low_free = SlotW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_nonempty && out_free) begin
          if (q_head.op == OP_GET && due_p_r) st_nxt = BK_SEND;
          else if (q_head.op == OP_FREE && q_head.idx < 8'(SlotCount)) st_nxt = BK_SCAN;
        end
      end
      BK_SEND: if (!rd_pend_r && k_r == slen_r) st_nxt = BK_SCAN;
      BK_SCAN: if (sc_r == (SlotW+1)'(SlotCount - 1)) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    due_nxt = due_r;
    due_p_nxt = due_p_r;
    fill_act_nxt = fill_act_r;
    fslot_nxt = fslot_r;
    fcnt_nxt = fcnt_r;
    ferr_nxt = ferr_r;
    ss_nxt = ss_r;
    k_nxt = k_r;
    slen_nxt = slen_r;
    sc_nxt = sc_r;
    rd_pend_nxt = 1'b0;
    ov_nxt = ov_r && !out_ch.ready;
    o_st_nxt = o_st_r;
    o_slot_nxt = o_slot_r;
    o_sec_nxt = o_sec_r;
    o_usec_nxt = o_usec_r;
    o_len_nxt = o_len_r;
    o_byte_nxt = o_byte_r;
    o_last_nxt = o_last_r;
    q_pop = 1'b0;
    wr_en = 1'b0;
    wr_addr = {fslot_r, fcnt_r[ByteW-1:0]};
    rd_en = 1'b0;
    rd_addr = {ss_r, k_r[ByteW-1:0]};
    set_en = 1'b0;
    set_slot = fslot_r;
    clr_en = 1'b0;
    clr_slot = ss_r;
    case (st_r)
      BK_IDLE: begin
        if (q_nonempty && out_free) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_ADD: begin
              logic act;
              logic [SlotW-1:0] fs;
              logic [LenW-1:0] fc;
              status_t fe;
              act = fill_act_r;
              fs = fslot_r;
              fc = fcnt_r;
              fe = ferr_r;
              if (!act) begin
                fc = '0;
                fs = any_free ? low_free : '0;
                fe = any_free ? ST_OK : ST_FULL;
              end
              if (fc < LenW'(MaxBytes)) begin
                wr_en = (fe == ST_OK);
                wr_addr = {fs, fc[ByteW-1:0]};
                fc = fc + LenW'(1);
              end else if (fe == ST_OK) begin
                fe = ST_TOO_LONG;
              end
              fill_act_nxt = !q_head.fin;
              fslot_nxt = fs;
              fcnt_nxt = q_head.fin ? '0 : fc;
              ferr_nxt = q_head.fin ? ST_OK : fe;
              if (q_head.fin) begin
                ov_nxt = 1'b1;
                o_st_nxt = fe;
                o_slot_nxt = (fe == ST_FULL) ? 4'd0 : 4'(fs);
                o_sec_nxt = '0;
                o_usec_nxt = '0;
                o_len_nxt = '0;
                o_byte_nxt = '0;
                o_last_nxt = 1'b1;
                if (fe == ST_OK) begin
                  set_en = 1'b1;
                  set_slot = fs;
                  valid_nxt[fs] = 1'b1;
                  if (!due_p_r || new_key < due_key) begin
                    due_nxt = fs;
                    due_p_nxt = 1'b1;
                  end
                end
              end
            end
            OP_GET: begin
              if (!due_p_r) begin
                ov_nxt = 1'b1;
                o_st_nxt = ST_EMPTY;
                o_slot_nxt = '0;
                o_sec_nxt = '0;
                o_usec_nxt = '0;
                o_len_nxt = '0;
                o_byte_nxt = '0;
                o_last_nxt = 1'b1;
              end else begin
                ss_nxt = due_r;
                k_nxt = '0;
                slen_nxt = (len_r[due_r] == '0) ? LenW'(1) : len_r[due_r];
              end
            end
            OP_FREE: begin
              ov_nxt = 1'b1;
              o_sec_nxt = '0;
              o_usec_nxt = '0;
              o_len_nxt = '0;
              o_byte_nxt = '0;
              o_last_nxt = 1'b1;
              if (q_head.idx >= 8'(SlotCount)) begin
                o_st_nxt = ST_BAD_SLOT;
                o_slot_nxt = '0;
              end else begin
                o_st_nxt = ST_OK;
                o_slot_nxt = 4'(q_head.idx);
                clr_en = 1'b1;
                clr_slot = SlotW'(q_head.idx);
                valid_nxt[SlotW'(q_head.idx)] = 1'b0;
                due_p_nxt = 1'b0;
                due_nxt = '0;
                sc_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      BK_SEND: begin
        // one memory read in flight at a time; the output reg takes its data
        if (rd_pend_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            o_st_nxt = ST_OK;
            o_slot_nxt = 4'(ss_r);
            o_sec_nxt = sec_r[ss_r];
            o_usec_nxt = usec_r[ss_r];
            o_len_nxt = slen_r;
            o_byte_nxt = rd_q_r;
            o_last_nxt = (k_r == slen_r);
          end else begin
            rd_pend_nxt = 1'b1;
          end
        end else if (k_r != slen_r) begin
          rd_en = 1'b1;
          rd_pend_nxt = 1'b1;
          k_nxt = k_r + LenW'(1);
        end else begin
          clr_en = 1'b1;
          valid_nxt[ss_r] = 1'b0;
          due_p_nxt = 1'b0;
          due_nxt = '0;
          sc_nxt = '0;
        end
      end
      BK_SCAN: begin
        if (valid_r[sc_idx] && (!due_p_r || cand_key < due_key)) begin
          due_nxt = sc_idx;
          due_p_nxt = 1'b1;
        end
        sc_nxt = sc_r + (SlotW+1)'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) pay_mem[wr_addr] <= q_head.data;
    if (rd_en) rd_q_r <= pay_mem[rd_addr];
    o_st_r <= o_st_nxt;
    o_slot_r <= o_slot_nxt;
    o_sec_r <= o_sec_nxt;
    o_usec_r <= o_usec_nxt;
    o_len_r <= o_len_nxt;
    o_byte_r <= o_byte_nxt;
    o_last_r <= o_last_nxt;
    ss_r <= ss_nxt;
    k_r <= k_nxt;
    slen_r <= slen_nxt;
    fslot_r <= fslot_nxt;
    if (!rst_n) begin
      st_r <= BK_IDLE;
      valid_r <= '0;
      due_r <= '0;
      due_p_r <= 1'b0;
      fill_act_r <= 1'b0;
      fcnt_r <= '0;
      ferr_r <= ST_OK;
      sc_r <= '0;
      rd_pend_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
        sec_r[i] <= '0;
        usec_r[i] <= '0;
        len_r[i] <= '0;
      end
    end else begin
      if (set_en) begin
        sec_r[set_slot] <= q_head.sec;
        usec_r[set_slot] <= q_head.usec;
        len_r[set_slot] <= fcnt_nxt == '0 ?
          fcnt_r + {6'd0, ferr_nxt == ST_OK && fcnt_r < LenW'(MaxBytes)} : fcnt_r;
      end
      if (clr_en) begin
        sec_r[clr_slot] <= '0;
        usec_r[clr_slot] <= '0;
        len_r[clr_slot] <= '0;
      end
      st_r <= st_nxt;
      valid_r <= valid_nxt;
      due_r <= due_nxt;
      due_p_r <= due_p_nxt;
      fill_act_r <= fill_act_nxt;
      fcnt_r <= fcnt_nxt;
      ferr_r <= ferr_nxt;
      sc_r <= sc_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.status = o_st_r;
  assign out_ch.slot_number = o_slot_r;
  assign out_ch.out_seconds = o_sec_r;
  assign out_ch.out_micros = o_usec_r;
  assign out_ch.packet_length = o_len_r;
  assign out_ch.out_byte = o_byte_r;
  assign out_ch.last_result = o_last_r;
endmodule

@@ src/tops_front.sv @@
// Front end: takes requests, drops unused opcodes, pushes commands to the queue.
// Depends on tops_pkg and tops_if.
module tops_front
  import tops_pkg::*;
(
  tops_in_if.sink in_ch,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full && (op_t'(in_ch.opcode) != OP_NONE);
  assign q_cmd = '{op: op_t'(in_ch.opcode), sec: in_ch.stamp_seconds,
                   usec: in_ch.stamp_micros, data: in_ch.data_byte,
                   fin: in_ch.final_byte, idx: in_ch.slot_index};
endmodule

@@ src/tops_checker.sv @@
// Port-level checks for the scheduler, bound to the top level.
// Depends on tops_pkg and the channel interfaces.
module tops_checker
  import tops_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] status,
  input logic [3:0] slot_number,
  input logic [6:0] packet_length,
  input logic [7:0] out_byte
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status <= 3'(ST_TOO_LONG))
    else $error("bad status code");
  a_nonget: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != 3'(ST_OK) |-> packet_length == 7'd0 && out_byte == 8'd0)
    else $error("error result with payload");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> packet_length <= 7'(MaxBytes))
    else $error("length too large");
  // full, empty and bad-slot results carry no slot
  a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == 3'(ST_FULL) || status == 3'(ST_EMPTY) ||
                  status == 3'(ST_BAD_SLOT)) |-> slot_number == 4'd0)
    else $error("slot number on slotless result");
endmodule

bind timestamp_ordered_packet_scheduler_unit tops_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .slot_number(out_ch.slot_number),
  .packet_length(out_ch.packet_length), .out_byte(out_ch.out_byte));

@@ sim/tops_tb_if.sv @@
// Testbench-side notes: the channel interfaces come from src/tops_if.sv.
// This file holds the expected-result and request record types shared by the testbench.
// Depends on tops_pkg.
`timescale 1ns / 100ps
package tops_tb_pkg;
  import tops_pkg::*;
  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [6:0]  len;
    logic [7:0]  data;
    logic        last;
  } resp_t;
  typedef struct packed {
    op_t         op;
    logic [31:0] sec;
    logic [19:0] usec;
    logic [7:0]  data;
    logic        fin;
    logic [7:0]  idx;
  } req_t;
endpackage

@@ sim/testbench.sv @@
// Testbench for the earliest-timestamp-first packet scheduler: random and directed
// add/get/free requests, predicted responses compared field by field.
// Depends on tops_pkg, tops_tb_pkg and the channel interfaces in src/tops_if.sv.
`timescale 1ns / 100ps
module testbench;
  import tops_pkg::*;
  import tops_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  tops_in_if in_ch();
  tops_out_if out_ch();

  timestamp_ordered_packet_scheduler_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // scheduler shadow state
  logic        busy_slot [SlotCount];
  logic [31:0] slot_sec [SlotCount];
  logic [19:0] slot_usec [SlotCount];
  logic [6:0]  slot_len [SlotCount];
  logic [7:0]  payload [SlotCount*MaxBytes];
  logic [3:0]  due_slot;
  logic        due_valid;
  logic [3:0]  fill_slot;
  logic [6:0]  fill_cnt;
  logic        filling;
  status_t     fill_err;

  req_t  pending_reqs [$];
  resp_t expected_resps [$];
  int    errors = 0;
  int    send_idle = 28, recv_idle = 77;
  int    n_resps = 0, n_reqs = 0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic earlier(logic [31:0] s1, logic [19:0] u1,
                                   logic [31:0] s2, logic [19:0] u2);
    return {s1, u1} < {s2, u2};
  endfunction

  function automatic void rescan_due();
    due_valid = 0;
    due_slot = 0;
    for (int i = 0; i < SlotCount; i++)
      if (busy_slot[i] && (!due_valid ||
          earlier(slot_sec[i], slot_usec[i], slot_sec[due_slot], slot_usec[due_slot]))) begin
        due_slot = 4'(i);
        due_valid = 1;
      end
  endfunction

  function automatic void push_resp(status_t st, logic [3:0] sl, logic [31:0] s,
                                    logic [19:0] u, logic [6:0] l, logic [7:0] d,
                                    logic lst);
    resp_t r;
    r.status = st; r.slot = sl; r.sec = s; r.usec = u; r.len = l; r.data = d; r.last = lst;
    expected_resps.push_back(r);
  endfunction

  function automatic void predict_request(req_t q);
    logic [3:0] s;
    case (q.op)
      OP_ADD: begin
        if (!filling) begin
          filling = 1;
          fill_cnt = 0;
          fill_err = ST_FULL;
          fill_slot = 0;
          for (int i = SlotCount - 1; i >= 0; i--)
            if (!busy_slot[i]) begin
              fill_slot = 4'(i);
              fill_err = ST_OK;
            end
        end
        if (fill_cnt < MaxBytes) begin
          if (fill_err == ST_OK) payload[fill_slot*MaxBytes + fill_cnt] = q.data;
          fill_cnt++;
        end else if (fill_err == ST_OK) begin
          fill_err = ST_TOO_LONG;
        end
        if (q.fin) begin
          filling = 0;
          if (fill_err != ST_OK) begin
            push_resp(fill_err, fill_err == ST_FULL ? 4'd0 : fill_slot, 0, 0, 0, 0, 1);
          end else begin
            busy_slot[fill_slot] = 1;
            slot_sec[fill_slot] = q.sec;
            slot_usec[fill_slot] = q.usec;
            slot_len[fill_slot] = fill_cnt;
            if (!due_valid || earlier(q.sec, q.usec, slot_sec[due_slot], slot_usec[due_slot]))
            begin
              due_slot = fill_slot;
              due_valid = 1;
            end
            push_resp(ST_OK, fill_slot, 0, 0, 0, 0, 1);
          end
          fill_err = ST_OK;
          fill_cnt = 0;
        end
      end
      OP_GET: begin
        if (!due_valid) begin
          push_resp(ST_EMPTY, 0, 0, 0, 0, 0, 1);
        end else begin
          s = due_slot;
          for (int k = 0; k < slot_len[s]; k++)
            push_resp(ST_OK, s, slot_sec[s], slot_usec[s], slot_len[s],
                      payload[s*MaxBytes + k], k + 1 == slot_len[s]);
          busy_slot[s] = 0; slot_sec[s] = 0; slot_usec[s] = 0; slot_len[s] = 0;
          rescan_due();
        end
      end
      OP_FREE: begin
        if (q.idx >= SlotCount) begin
          push_resp(ST_BAD_SLOT, 0, 0, 0, 0, 0, 1);
        end else begin
          s = q.idx[3:0];
          busy_slot[s] = 0; slot_sec[s] = 0; slot_usec[s] = 0; slot_len[s] = 0;
          rescan_due();
          push_resp(ST_OK, s, 0, 0, 0, 0, 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic req_t mk(op_t op, logic [7:0] d = 0, logic fin = 0,
                              logic [31:0] s = 0, logic [19:0] u = 0, logic [7:0] idx = 0);
    req_t q;
    q.op = op; q.data = d; q.fin = fin; q.sec = s; q.usec = u; q.idx = idx;
    return q;
  endfunction

  // whole packet of n bytes; noise stamps on non-final bytes
  task automatic queue_packet(int n, logic [31:0] s, logic [19:0] u);
    for (int k = 0; k < n; k++)
      pending_reqs.push_back(mk(OP_ADD, 8'($urandom), k == n - 1,
                                k == n - 1 ? s : $urandom,
                                k == n - 1 ? u : 20'($urandom_range(0, 999999)),
                                8'($urandom)));
  endtask

  function automatic logic [31:0] rand_sec();
    case ($urandom_range(0, 3))
      0: return 32'hffffffff;
      1: return 0;
      2: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // driver: accept bookkeeping at the rising edge, new request at the falling edge
  logic drive_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      drive_hold <= 0;
    end else begin
      drive_hold <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        predict_request(pending_reqs.pop_front());
        n_reqs++;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || drive_hold) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_ch.valid <= 1;
        in_ch.opcode <= pending_reqs[0].op;
        in_ch.stamp_seconds <= pending_reqs[0].sec;
        in_ch.stamp_micros <= pending_reqs[0].usec;
        in_ch.data_byte <= pending_reqs[0].data;
        in_ch.final_byte <= pending_reqs[0].fin;
        in_ch.slot_index <= pending_reqs[0].idx;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t e;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_resps++;
      if (expected_resps.size() == 0) begin
        $error("unexpected response status=%0d slot=%0d", out_ch.status, out_ch.slot_number);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.slot_number !== e.slot) begin
          $error("slot_number exp %0d got %0d", e.slot, out_ch.slot_number); errors++;
        end
        if (out_ch.out_seconds !== e.sec) begin
          $error("out_seconds exp %0h got %0h", e.sec, out_ch.out_seconds); errors++;
        end
        if (out_ch.out_micros !== e.usec) begin
          $error("out_micros exp %0d got %0d", e.usec, out_ch.out_micros); errors++;
        end
        if (out_ch.packet_length !== e.len) begin
          $error("packet_length exp %0d got %0d", e.len, out_ch.packet_length); errors++;
        end
        if (out_ch.out_byte !== e.data) begin
          $error("out_byte exp %0h got %0h", e.data, out_ch.out_byte); errors++;
        end
        if (out_ch.last_result !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, out_ch.last_result); errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin
    in_ch.valid = 0; in_ch.opcode = OP_NONE; in_ch.stamp_seconds = 0;
    in_ch.stamp_micros = 0; in_ch.data_byte = 0; in_ch.final_byte = 0; in_ch.slot_index = 0;
    out_ch.ready = 0;
    for (int i = 0; i < SlotCount; i++) begin
      busy_slot[i] = 0; slot_sec[i] = 0; slot_usec[i] = 0; slot_len[i] = 0;
    end
    due_slot = 0; due_valid = 0; fill_slot = 0; fill_cnt = 0; filling = 0; fill_err = ST_OK;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // directed: empty get, bad and empty frees, ignored opcode, extremes, too long, ties
    pending_reqs.push_back(mk(OP_GET));
    pending_reqs.push_back(mk(OP_FREE, 0, 0, 0, 0, 8'hff));
    pending_reqs.push_back(mk(OP_FREE, 0, 0, 0, 0, 8'd16));
    pending_reqs.push_back(mk(OP_FREE, 0, 0, 0, 0, 8'd15));
    pending_reqs.push_back(mk(OP_NONE, 8'hff, 1, '1, '1, 8'hff));
    queue_packet(1, 32'hffffffff, 999999);
    queue_packet(2, 0, 0);
    queue_packet(1, 0, 0);
    pending_reqs.push_back(mk(OP_ADD, 8'h55));
    pending_reqs.push_back(mk(OP_GET));
    pending_reqs.push_back(mk(OP_FREE, 0, 0, 0, 0, 8'd0));
    pending_reqs.push_back(mk(OP_ADD, 8'haa, 1, 5, 7));
    queue_packet(MaxBytes + 1, 1, 1);
    queue_packet(MaxBytes, 3, 999999);
    pending_reqs.push_back(mk(OP_GET));
    pending_reqs.push_back(mk(OP_GET));
    pending_reqs.push_back(mk(OP_GET));

    for (int ph = 0; ph < 3; ph++) begin
      wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
      repeat (40) @(posedge clk);
      send_idle = ph == 0 ? 28 : ph == 1 ? 77 : 0;
      recv_idle = ph == 0 ? 77 : ph == 1 ? 28 : 0;
      // the queue is empty here and fills in zero time, so its size counts requests
      while (pending_reqs.size() < 25) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // mostly short packets, rarely long
            queue_packet($urandom_range(0, 7) == 0 ? $urandom_range(1, MaxBytes + 1)
                                                   : $urandom_range(1, 4),
                         rand_sec(),
                         $urandom_range(0, 1) ? 20'($urandom_range(0, 999999)) : 20'(999999));
          end
          4: begin
            // fill the table to exercise the full status
            for (int j = 0; j < SlotCount + 1; j++) queue_packet(1, rand_sec(), 0);
          end
          5, 6, 7: pending_reqs.push_back(mk(OP_GET));
          8: begin
            pending_reqs.push_back(mk(OP_FREE, 0, 0, 0, 0,
              $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, SlotCount - 1))));
          end
          default: begin
            pending_reqs.push_back(mk(op_t'($urandom_range(0, 3)), 8'($urandom), 0, $urandom,
                                      20'($urandom_range(0, 999999)), 8'($urandom)));
          end
        endcase
      end
      queue_packet(1, 9, 9);
    end

    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d requests accepted, %0d responses checked over three idle profiles",
             n_reqs, n_resps);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
